@@ rtl/ssfr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssfr_pkg
// Shared types and constants for the start string / stop byte framer.
// ----------------------------------------------------------------------------
package ssfr_pkg;

    localparam int BUF_DEPTH_DEFAULT = 64;

    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 6;
    localparam int PATTERN_W  = 64;
    localparam int LEN_W      = 4;
    localparam int MATCH_W    = 3;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    // register indexes, taken from paddr[4:3]
    localparam logic [1:0] REG_START_PATTERN = 2'd0;
    localparam logic [1:0] REG_START_LENGTH  = 2'd1;
    localparam logic [1:0] REG_STOP_BYTE     = 2'd2;

    localparam logic [LEN_W-1:0]  START_LENGTH_RESET = 4'd1;
    localparam logic [BYTE_W-1:0] STOP_BYTE_RESET    = 8'd10;
    localparam logic [LEN_W-1:0]  START_LENGTH_MAX   = 4'd8;

    typedef enum logic [1:0] {
        ST_HUNT = 2'd0,
        ST_RECV = 2'd1,
        ST_DONE = 2'd2,
        ST_OVFL = 2'd3
    } status_t;

    typedef struct packed {
        logic [PATTERN_W-1:0] start_pattern;
        logic [LEN_W-1:0]     start_length;
        logic [BYTE_W-1:0]    stop_byte;
    } cfg_t;

    typedef struct packed {
        status_t           status;
        logic              byte_stored;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] byte_value;
        logic              last;
    } result_t;

endpackage

@@ rtl/ssfr_cfg.sv @@
// ----------------------------------------------------------------------------
// ssfr_cfg
// APB-style register file holding the start string, its length and the stop
// byte.
// ----------------------------------------------------------------------------
module ssfr_cfg
    import ssfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_sel;
    logic       wr_en;

    assign reg_sel = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_START_PATTERN: cfg_next.start_pattern = pwdata;
                REG_START_LENGTH:  cfg_next.start_length  = pwdata[LEN_W-1:0];
                REG_STOP_BYTE:     cfg_next.stop_byte     = pwdata[BYTE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_START_PATTERN: prdata = cfg_reg.start_pattern;
            REG_START_LENGTH:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, cfg_reg.start_length};
            REG_STOP_BYTE:     prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, cfg_reg.stop_byte};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_pattern <= '0;
            cfg_reg.start_length  <= START_LENGTH_RESET;
            cfg_reg.stop_byte     <= STOP_BYTE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/ssfr_outbuf.sv @@
// ----------------------------------------------------------------------------
// ssfr_outbuf
// Two-entry result buffer: output register plus skid entry, so one stalled
// result does not block the next item.
// ----------------------------------------------------------------------------
module ssfr_outbuf
    import ssfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_valid,
    output logic    wr_ready,
    input  result_t wr_data,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rd_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    wr_fire;
    logic    rd_fire;

    assign wr_ready = !skid_valid_reg;
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = out_valid_reg && rd_ready;
    assign rd_valid = out_valid_reg;
    assign rd_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_fire)
            begin
                if (!out_valid_reg || rd_fire)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (rd_fire)
            begin
                if (skid_valid_reg)
                    skid_valid_reg <= 1'b0;
                else
                    out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            if (!out_valid_reg || rd_fire)
                out_data_reg <= wr_data;
            else
                skid_data_reg <= wr_data;
        end
        else if (rd_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

endmodule

@@ rtl/start_string_stop_byte_framer_unit.sv @@
// ----------------------------------------------------------------------------
// start_string_stop_byte_framer_unit
// Byte-serial framer: hunts for a start string, then passes packet bytes
// with their index until the stop byte or a full buffer ends the packet.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   item; output channel (out_valid/out_ready) returns exactly one result per
//   item: status, byte_stored, byte_index, byte_value, last.
//   throughput is one item per cycle while in_ready is high; the framer
//   state (match count, receive flag, write index) updates in the cycle the
//   item is taken. the result is registered into the output register, or
//   into the skid entry while the output register holds a stalled result.
//   a two-entry output buffer absorbs one stalled result; in_ready drops only
//   while both entries are full, and comes back the cycle after out_ready.
//   the APB port sets start_pattern (addr 0), start_length (addr 8) and
//   stop_byte (addr 16); write it only while the block is idle.
//   reset puts the framer in hunting with match count and write index zero,
//   empties the output buffer, and loads start_length 1, stop_byte 10 and a
//   zero start pattern.
// ----------------------------------------------------------------------------
module start_string_stop_byte_framer_unit
    import ssfr_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     rx_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic                  byte_stored,
    output logic [IDX_W-1:0]      byte_index,
    output logic [BYTE_W-1:0]     byte_value,
    output logic                  last
);

    localparam int WI_W = $clog2(BUF_DEPTH);
    localparam logic [WI_W-1:0] WI_LIMIT = WI_W'(BUF_DEPTH - 1);

    cfg_t              cfg;
    result_t           res;
    result_t           out_res;
    logic              in_fire;

    logic              receiving_reg;
    logic              receiving_next;
    logic [MATCH_W-1:0] match_count_reg;
    logic [MATCH_W-1:0] match_count_next;
    logic [WI_W-1:0]   write_index_reg;
    logic [WI_W-1:0]   write_index_next;

    logic [LEN_W-1:0]  eff_len;
    logic [BYTE_W-1:0] expect_byte;
    logic [LEN_W-1:0]  match_inc;
    logic [WI_W-1:0]   wi_inc;
    logic [IDX_W-1:0]  idx_low;

    ssfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_fire = in_valid && in_ready;

    // start length saturates into 1..8
    always_comb
    begin
        if (cfg.start_length == '0)
            eff_len = LEN_W'(1);
        else if (cfg.start_length > START_LENGTH_MAX)
            eff_len = START_LENGTH_MAX;
        else
            eff_len = cfg.start_length;
    end

    assign expect_byte = cfg.start_pattern[match_count_reg*BYTE_W +: BYTE_W];
    assign match_inc   = {1'b0, match_count_reg} + LEN_W'(1);
    assign wi_inc      = write_index_reg + WI_W'(1);

    generate
        if (WI_W >= IDX_W)
        begin : g_idx_wide
            assign idx_low = write_index_reg[IDX_W-1:0];
        end
        else
        begin : g_idx_narrow
            assign idx_low = {{(IDX_W-WI_W){1'b0}}, write_index_reg};
        end
    endgenerate

    always_comb
    begin
        receiving_next   = receiving_reg;
        match_count_next = match_count_reg;
        write_index_next = write_index_reg;
        res.status       = ST_HUNT;
        res.byte_stored  = 1'b0;
        res.byte_index   = '0;
        res.byte_value   = '0;
        res.last         = 1'b0;

        if (!receiving_reg)
        begin
            // a mismatch clears the count without rechecking this byte
            if (rx_byte == expect_byte)
            begin
                if (match_inc >= eff_len)
                begin
                    match_count_next = '0;
                    write_index_next = '0;
                    receiving_next   = 1'b1;
                    res.status       = ST_RECV;
                end
                else
                begin
                    match_count_next = match_inc[MATCH_W-1:0];
                end
            end
            else
            begin
                match_count_next = '0;
            end
        end
        else
        begin
            res.byte_stored = 1'b1;
            res.byte_index  = idx_low;
            res.byte_value  = rx_byte;
            if (rx_byte == cfg.stop_byte)
            begin
                write_index_next = '0;
                receiving_next   = 1'b0;
                res.status       = ST_DONE;
                res.last         = 1'b1;
            end
            else if (wi_inc >= WI_LIMIT)
            begin
                write_index_next = '0;
                receiving_next   = 1'b0;
                res.status       = ST_OVFL;
                res.last         = 1'b1;
            end
            else
            begin
                write_index_next = wi_inc;
                res.status       = ST_RECV;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg   <= 1'b0;
            match_count_reg <= '0;
            write_index_reg <= '0;
        end
        else if (in_fire)
        begin
            receiving_reg   <= receiving_next;
            match_count_reg <= match_count_next;
            write_index_reg <= write_index_next;
        end
    end

    ssfr_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_data  (res),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_data  (out_res)
    );

    assign status      = out_res.status;
    assign byte_stored = out_res.byte_stored;
    assign byte_index  = out_res.byte_index;
    assign byte_value  = out_res.byte_value;
    assign last        = out_res.last;

    // write index only counts inside a packet
    a_idx_clear_hunting: assert property (@(posedge clk) disable iff (!rst_n)
        !receiving_reg |-> write_index_reg == '0)
        else $error("write index nonzero while hunting");

    a_match_clear_recv: assert property (@(posedge clk) disable iff (!rst_n)
        receiving_reg |-> match_count_reg == '0)
        else $error("match count nonzero while receiving");

    a_stop_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && receiving_reg && rx_byte == cfg.stop_byte |=> !receiving_reg)
        else $error("stop byte did not end the packet");

    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> status == ST_DONE || status == ST_OVFL)
        else $error("last set without packet end status");

    a_stored_on_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_stored |-> !last && byte_value == '0)
        else $error("hunting result carries payload");

endmodule

@@ tb/tb_start_string_stop_byte_framer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_start_string_stop_byte_framer_unit
// Feeds byte streams of framed packets, broken start strings and noise into
// the framer under changing start string / stop byte settings, predicts each
// result from a local model of the hunt and receive logic, and compares
// every returned result field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_start_string_stop_byte_framer_unit;
    import ssfr_pkg::*;

    localparam int BUF_DEPTH   = BUF_DEPTH_DEFAULT;
    localparam int STALL_LIMIT = 2000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     rx_byte   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic                  byte_stored;
    logic [IDX_W-1:0]      byte_index;
    logic [BYTE_W-1:0]     byte_value;
    logic                  last;

    // mirror of the configuration registers and of the framer state
    cfg_t cfg;
    bit   in_packet;
    int   match_cnt;
    int   wr_count;

    logic [BYTE_W-1:0] rx_bytes_q[$];
    result_t           framer_out_q[$];

    bit quiet;
    int send_gap;
    int stall_left;
    int idle_cycles;
    int mismatches;

    start_string_stop_byte_framer_unit #(.BUF_DEPTH(BUF_DEPTH)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .byte_stored(byte_stored),
        .byte_index (byte_index),
        .byte_value (byte_value),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int start_span();
        if (cfg.start_length == 0)
            return 1;
        if (cfg.start_length > START_LENGTH_MAX)
            return int'(START_LENGTH_MAX);
        return int'(cfg.start_length);
    endfunction

    function automatic result_t frame_rx_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        r = '0;
        r.status = ST_HUNT;
        if (!in_packet)
        begin
            // a mismatching byte is not tried again as the first start byte
            match_cnt = (b == cfg.start_pattern[match_cnt*8 +: 8]) ? match_cnt + 1 : 0;
            if (match_cnt >= start_span())
            begin
                match_cnt = 0;
                wr_count  = 0;
                in_packet = 1'b1;
                r.status  = ST_RECV;
            end
        end
        else
        begin
            r.byte_stored = 1'b1;
            r.byte_index  = wr_count[IDX_W-1:0];
            r.byte_value  = b;
            wr_count++;
            if (b == cfg.stop_byte)
            begin
                wr_count  = 0;
                in_packet = 1'b0;
                r.status  = ST_DONE;
                r.last    = 1'b1;
            end
            else if (wr_count >= BUF_DEPTH - 1)
            begin
                wr_count  = 0;
                in_packet = 1'b0;
                r.status  = ST_OVFL;
                r.last    = 1'b1;
            end
            else
            begin
                r.status = ST_RECV;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                framer_out_q.push_back(frame_rx_byte(rx_byte));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0 && !quiet)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (rx_bytes_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_bytes_q.pop_front();
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 10);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_mon
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (framer_out_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h %0h %0h %0h %0h",
                             $time, status, byte_stored, byte_index, byte_value, last);
                    mismatches++;
                end
                else
                begin
                    want = framer_out_q.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("byte_stored", 32'(want.byte_stored), 32'(byte_stored));
                    check_field("byte_index", 32'(want.byte_index), 32'(byte_index));
                    check_field("byte_value", 32'(want.byte_value), 32'(byte_value));
                    check_field("last", 32'(want.last), 32'(last));
                end
            end
            if (stall_left > 0 && !quiet)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 10);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_PATTERN: cfg.start_pattern = value;
            REG_START_LENGTH:  cfg.start_length  = value[LEN_W-1:0];
            REG_STOP_BYTE:     cfg.stop_byte     = value[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_framing(input logic [PATTERN_W-1:0] pattern,
                               input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] stop);
        apb_write(REG_START_PATTERN, pattern);
        apb_write(REG_START_LENGTH, CFG_DATA_W'(len));
        apb_write(REG_STOP_BYTE, CFG_DATA_W'(stop));
    endtask

    // hold the sender until every result is back, so the block is idle
    task automatic drain();
        do @(negedge clk);
        while (rx_bytes_q.size() != 0 || in_valid || framer_out_q.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic push_start();
        for (int k = 0; k < start_span(); k++)
            rx_bytes_q.push_back(cfg.start_pattern[k*8 +: 8]);
    endtask

    task automatic push_packet(input int n_payload, input bit closed);
        logic [BYTE_W-1:0] b;
        push_start();
        for (int k = 0; k < n_payload; k++)
        begin
            do b = BYTE_W'($urandom); while (b == cfg.stop_byte);
            rx_bytes_q.push_back(b);
        end
        if (closed)
            rx_bytes_q.push_back(cfg.stop_byte);
    endtask

    // start string cut short by a wrong byte
    task automatic push_broken();
        int                p;
        logic [BYTE_W-1:0] b;
        p = $urandom_range(0, start_span() - 1);
        for (int k = 0; k < p; k++)
            rx_bytes_q.push_back(cfg.start_pattern[k*8 +: 8]);
        do b = BYTE_W'($urandom); while (b == cfg.start_pattern[p*8 +: 8]);
        rx_bytes_q.push_back(b);
    endtask

    task automatic gen_traffic(input int n_items);
        int goal;
        int pick;
        goal = rx_bytes_q.size() + n_items;
        while (rx_bytes_q.size() < goal)
        begin
            pick = $urandom_range(0, 29);
            if (pick < 20)
                push_packet($urandom_range(0, 10), 1'b1);
            else if (pick < 21)
                push_packet($urandom_range(58, 66), 1'($urandom_range(0, 1)));
            else if (pick < 26)
                push_broken();
            else
                repeat ($urandom_range(1, 4)) rx_bytes_q.push_back(BYTE_W'($urandom));
        end
    endtask

    initial
    begin
        cfg.start_pattern = '0;
        cfg.start_length  = START_LENGTH_RESET;
        cfg.stop_byte     = STOP_BYTE_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: single zero start byte, stop byte 0x0a
        rx_bytes_q = '{8'hFF, 8'h0A, 8'h00, 8'hFF, 8'h00, 8'h7F, 8'h80, 8'h0A,
                       8'h00, 8'h0A};
        drain();

        // length above eight saturates to eight
        set_framing({$urandom, $urandom}, 4'd12, BYTE_W'($urandom));
        push_packet(2, 1'b1);
        push_broken();
        push_packet(0, 1'b1);
        gen_traffic(35);
        drain();

        // length zero acts as one; stop byte on the last buffer slot wins
        set_framing({$urandom, $urandom}, 4'd0, 8'h00);
        push_packet(BUF_DEPTH - 2, 1'b1);
        gen_traffic(35);
        drain();

        set_framing('1, START_LENGTH_MAX, 8'hFF);
        gen_traffic(35);
        drain();

        // repeated start bytes: a mismatch does not restart the match
        set_framing({$urandom, 8'h00, 24'hAA5555}, 4'd3, BYTE_W'($urandom_range(0, 84)));
        rx_bytes_q.push_back(8'h55);
        rx_bytes_q.push_back(8'h55);
        rx_bytes_q.push_back(8'h55);
        rx_bytes_q.push_back(8'hAA);
        push_packet(BUF_DEPTH - 1, 1'b0);
        gen_traffic(35);
        drain();

        set_framing({$urandom, $urandom}, 4'd15, BYTE_W'($urandom));
        gen_traffic(35);
        drain();

        set_framing({$urandom, $urandom}, LEN_W'($urandom_range(1, 8)), BYTE_W'($urandom));
        gen_traffic(35);
        drain();

        quiet = 1'b1;
        set_framing({$urandom, $urandom}, LEN_W'($urandom_range(1, 8)), BYTE_W'($urandom));
        gen_traffic(35);
        drain();

        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
